[design/aec_pkg.sv]
// Shared types, codes and helpers for the alarm escalation controller.
`timescale 1ns / 1ps

package aec_pkg;

  // Field widths
  localparam int OP_W     = 3;
  localparam int MINUTE_W = 11;
  localparam int CFG_W    = 11;
  localparam int INDEX_W  = 3;
  localparam int CODE_W   = 3;
  localparam int WAIT_W   = 17;
  localparam int BEEP_W   = 3;

  // Event opcodes
  localparam logic [OP_W-1:0] OP_REEVALUATE = 3'd0;
  localparam logic [OP_W-1:0] OP_START      = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP       = 3'd2;
  localparam logic [OP_W-1:0] OP_LINK_LOST  = 3'd3;
  localparam logic [OP_W-1:0] OP_ACK        = 3'd4;
  localparam logic [OP_W-1:0] OP_TICK       = 3'd5;

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_ALERT_ENABLE  = 3'd0;
  localparam logic [INDEX_W-1:0] REG_WINDOW_START  = 3'd1;
  localparam logic [INDEX_W-1:0] REG_WINDOW_END    = 3'd2;
  localparam logic [INDEX_W-1:0] REG_FIRST_DELAY   = 3'd3;
  localparam logic [INDEX_W-1:0] REG_SECOND_DELAY  = 3'd4;
  localparam logic [INDEX_W-1:0] REG_PUSH_ENABLE   = 3'd5;
  localparam logic [INDEX_W-1:0] REG_BUZZER_ENABLE = 3'd6;

  // Reported alert state codes
  localparam logic [CODE_W-1:0] CODE_DISARMED  = 3'd0;
  localparam logic [CODE_W-1:0] CODE_ARMED     = 3'd1;
  localparam logic [CODE_W-1:0] CODE_PENDING   = 3'd2;
  localparam logic [CODE_W-1:0] CODE_PUSH_SENT = 3'd3;
  localparam logic [CODE_W-1:0] CODE_BUZZING   = 3'd4;
  localparam logic [CODE_W-1:0] CODE_ACKED     = 3'd5;

  // Alert state machine, one-hot
  typedef enum logic [5:0] {
    AS_DISARMED  = 6'b000001,
    AS_ARMED     = 6'b000010,
    AS_PENDING   = 6'b000100,
    AS_PUSH_SENT = 6'b001000,
    AS_BUZZING   = 6'b010000,
    AS_ACKED     = 6'b100000
  } alert_t;

  // Escalation phase machine, one-hot
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_FIRST  = 4'b0010,
    PH_SECOND = 4'b0100,
    PH_BEEP   = 4'b1000
  } phase_t;

  // Encode the one-hot alert state into its reported code.
  function automatic logic [CODE_W-1:0] alert_code(input alert_t a);
    logic [CODE_W-1:0] code;
    case (a)
      AS_DISARMED:  code = CODE_DISARMED;
      AS_ARMED:     code = CODE_ARMED;
      AS_PENDING:   code = CODE_PENDING;
      AS_PUSH_SENT: code = CODE_PUSH_SENT;
      AS_BUZZING:   code = CODE_BUZZING;
      AS_ACKED:     code = CODE_ACKED;
      default:      code = CODE_DISARMED;
    endcase
    return code;
  endfunction

endpackage

[design/alarm_escalation_controller.sv]
// Alarm escalation controller: window check, alert state and escalation sequencer.
`timescale 1ns / 1ps

//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+---------------------------------------------
//  in       | input     | in_valid / in_stall | opcode, minute_of_day, clock_valid,
//           |           |                     | therapy_active
//  out      | output    | out_valid/out_stall | alert_state, push_request, beep_pulse,
//           |           |                     | escalation_busy
//  cfg      | input     | cfg_wr_en           | cfg_index, cfg_data
//
// One request is taken per cycle while in_stall is low; its result passes through the input
// register, the combinational update and the result register before it reaches the outputs.
// Reset (synchronous, active high) restores the configuration defaults and the
// disarmed, idle state. A stalled result holds in the result register while one more
// request waits in the input register; further requests are stalled until it moves.

module alarm_escalation_controller #(
  parameter int BEEP_COUNT         = 5,
  parameter int SECONDS_PER_MINUTE = 60
) (
  input  logic                         clk,
  input  logic                         rst,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [aec_pkg::OP_W-1:0]     opcode,
  input  logic [aec_pkg::MINUTE_W-1:0] minute_of_day,
  input  logic                         clock_valid,
  input  logic                         therapy_active,
  // Output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [aec_pkg::CODE_W-1:0]   alert_state,
  output logic                         push_request,
  output logic                         beep_pulse,
  output logic                         escalation_busy,
  // Configuration write port
  input  logic                         cfg_wr_en,
  input  logic [aec_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [aec_pkg::CFG_W-1:0]    cfg_data
);

  import aec_pkg::*;

  localparam int SPM_W   = $clog2(SECONDS_PER_MINUTE + 1);
  localparam int LIMIT_W = CFG_W + SPM_W;
  localparam int CMP_W   = (LIMIT_W > WAIT_W) ? LIMIT_W : WAIT_W;

  // Configuration registers
  logic              alert_enable;
  logic [CFG_W-1:0]  window_start;
  logic [CFG_W-1:0]  window_end;
  logic [CFG_W-1:0]  first_delay_minutes;
  logic [CFG_W-1:0]  second_delay_minutes;
  logic              push_enable;
  logic              buzzer_enable;

  // Input register
  logic                in_reg_valid;
  logic [OP_W-1:0]     op_q;
  logic [MINUTE_W-1:0] minute_q;
  logic                clock_valid_q;
  logic                therapy_q;

  // Controller state
  alert_t              current_alert;
  phase_t              escalation_phase;
  logic [WAIT_W-1:0]   seconds_waited;
  logic [BEEP_W-1:0]   beeps_left;

  alert_t              current_alert_next;
  phase_t              escalation_phase_next;
  logic [WAIT_W-1:0]   seconds_waited_next;
  logic [BEEP_W-1:0]   beeps_left_next;
  logic                push_next;
  logic                beep_next;

  logic                advance;
  logic                in_window;
  logic [CFG_W-1:0]    delay_sel;
  logic [LIMIT_W-1:0]  wait_limit;
  logic [WAIT_W-1:0]   seconds_inc;

  // The input register moves on whenever the result register is free or being taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_reg_valid && !advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alert_enable         <= 1'b0;
      window_start         <= CFG_W'(1380);
      window_end           <= CFG_W'(360);
      first_delay_minutes  <= CFG_W'(5);
      second_delay_minutes <= CFG_W'(5);
      push_enable          <= 1'b0;
      buzzer_enable        <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ALERT_ENABLE:  alert_enable         <= cfg_data[0];
        REG_WINDOW_START:  window_start         <= cfg_data;
        REG_WINDOW_END:    window_end           <= cfg_data;
        REG_FIRST_DELAY:   first_delay_minutes  <= cfg_data;
        REG_SECOND_DELAY:  second_delay_minutes <= cfg_data;
        REG_PUSH_ENABLE:   push_enable          <= cfg_data[0];
        REG_BUZZER_ENABLE: buzzer_enable        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_q          <= opcode;
      minute_q      <= minute_of_day;
      clock_valid_q <= clock_valid;
      therapy_q     <= therapy_active;
    end
  end

  // Window check; a window may wrap past midnight, and equal ends mean all day.
  always_comb begin
    if (!clock_valid_q) begin
      in_window = 1'b0;
    end else if (window_start == window_end) begin
      in_window = 1'b1;
    end else if (window_start < window_end) begin
      in_window = (minute_q >= window_start) && (minute_q < window_end);
    end else begin
      in_window = (minute_q >= window_start) || (minute_q < window_end);
    end
  end

  // Delay limit of the current wait phase, in seconds.
  assign delay_sel   = (escalation_phase == PH_FIRST) ? first_delay_minutes
                                                      : second_delay_minutes;
  assign wait_limit  = LIMIT_W'(delay_sel) * LIMIT_W'(SECONDS_PER_MINUTE);
  assign seconds_inc = seconds_waited + WAIT_W'(1);

  // Event handling for one request.
  always_comb begin
    logic do_after_first;
    logic do_buzzer;
    logic do_abort;

    current_alert_next    = current_alert;
    escalation_phase_next = escalation_phase;
    seconds_waited_next   = seconds_waited;
    beeps_left_next       = beeps_left;
    push_next             = 1'b0;
    beep_next             = 1'b0;
    do_after_first        = 1'b0;
    do_buzzer             = 1'b0;
    do_abort              = 1'b0;

    case (op_q)
      OP_REEVALUATE: begin
        if (!alert_enable || !clock_valid_q) begin
          if (current_alert != AS_DISARMED && current_alert != AS_ACKED) begin
            do_abort = 1'b1;
          end
        end else if (in_window && therapy_q && current_alert == AS_DISARMED) begin
          current_alert_next = AS_ARMED;
        end else if (!in_window && current_alert != AS_DISARMED &&
                     current_alert != AS_ACKED) begin
          do_abort = 1'b1;
        end
      end
      OP_START: begin
        if (alert_enable && in_window) begin
          escalation_phase_next = PH_IDLE;
          seconds_waited_next   = '0;
          beeps_left_next       = '0;
          current_alert_next    = AS_ARMED;
        end
      end
      OP_STOP: begin
        if (alert_enable && current_alert == AS_ARMED) begin
          if (!in_window) begin
            current_alert_next = AS_DISARMED;
          end else begin
            current_alert_next    = AS_PENDING;
            escalation_phase_next = PH_FIRST;
            seconds_waited_next   = '0;
            beeps_left_next       = '0;
            do_after_first        = (first_delay_minutes == '0);
          end
        end
      end
      OP_LINK_LOST: begin
        if (alert_enable && current_alert != AS_DISARMED) begin
          do_abort = 1'b1;
        end
      end
      OP_ACK: begin
        if (current_alert != AS_DISARMED && current_alert != AS_ACKED) begin
          escalation_phase_next = PH_IDLE;
          seconds_waited_next   = '0;
          beeps_left_next       = '0;
          current_alert_next    = AS_ACKED;
        end
      end
      OP_TICK: begin
        case (escalation_phase)
          PH_FIRST, PH_SECOND: begin
            seconds_waited_next = seconds_inc;
            if (CMP_W'(seconds_inc) >= CMP_W'(wait_limit)) begin
              if (escalation_phase == PH_FIRST) begin
                do_after_first = 1'b1;
              end else begin
                do_buzzer = 1'b1;
              end
            end else if (!alert_enable || !in_window) begin
              do_abort = 1'b1;
            end
          end
          PH_BEEP: begin
            if (beeps_left != '0) begin
              beep_next       = 1'b1;
              beeps_left_next = beeps_left - BEEP_W'(1);
            end else begin
              escalation_phase_next = PH_IDLE;
              seconds_waited_next   = '0;
              beeps_left_next       = '0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    // End of the first wait: push stage, then the second wait or the buzzer.
    if (do_after_first) begin
      if (current_alert_next != AS_PENDING) begin
        escalation_phase_next = PH_IDLE;
        seconds_waited_next   = '0;
        beeps_left_next       = '0;
      end else if (!in_window) begin
        do_abort = 1'b1;
      end else begin
        if (push_enable) begin
          current_alert_next = AS_PUSH_SENT;
          push_next          = 1'b1;
        end
        if (push_enable && buzzer_enable && second_delay_minutes != '0) begin
          if (!alert_enable) begin
            do_abort = 1'b1;
          end else begin
            escalation_phase_next = PH_SECOND;
            seconds_waited_next   = '0;
          end
        end else begin
          do_buzzer = 1'b1;
        end
      end
    end

    // Buzzer stage: first beep at once, the rest on the following ticks.
    if (do_buzzer) begin
      if (!in_window) begin
        do_abort = 1'b1;
      end else if (buzzer_enable) begin
        current_alert_next    = AS_BUZZING;
        beep_next             = 1'b1;
        beeps_left_next       = BEEP_W'(BEEP_COUNT - 1);
        escalation_phase_next = PH_BEEP;
        seconds_waited_next   = '0;
      end else begin
        escalation_phase_next = PH_IDLE;
        seconds_waited_next   = '0;
        beeps_left_next       = '0;
      end
    end

    // Abort ends the sequence and disarms; a push already raised in this step still goes out.
    if (do_abort) begin
      current_alert_next    = AS_DISARMED;
      escalation_phase_next = PH_IDLE;
      seconds_waited_next   = '0;
      beeps_left_next       = '0;
      beep_next             = 1'b0;
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      current_alert    <= AS_DISARMED;
      escalation_phase <= PH_IDLE;
      seconds_waited   <= '0;
      beeps_left       <= '0;
    end else if (in_reg_valid && advance) begin
      current_alert    <= current_alert_next;
      escalation_phase <= escalation_phase_next;
      seconds_waited   <= seconds_waited_next;
      beeps_left       <= beeps_left_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_reg_valid && advance) begin
      alert_state     <= alert_code(current_alert_next);
      push_request    <= push_next;
      beep_pulse      <= beep_next;
      escalation_busy <= (escalation_phase_next != PH_IDLE);
    end
  end

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the alarm escalation controller.
`timescale 1ns / 1ps

module tb_top;
  import aec_pkg::*;

  localparam int SECS_PER_MINUTE = 60;
  localparam int BEEPS           = 5;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [MINUTE_W-1:0] minute;
    logic                cv;
    logic                therapy;
  } request_t;

  typedef struct {
    logic [CODE_W-1:0] state;
    logic              push;
    logic              beep;
    logic              busy;
  } alarm_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     opcode         = '0;
  logic [MINUTE_W-1:0] minute_of_day  = '0;
  logic                clock_valid    = 1'b0;
  logic                therapy_active = 1'b0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [CODE_W-1:0]   alert_state;
  logic                push_request;
  logic                beep_pulse;
  logic                escalation_busy;
  logic                cfg_wr_en      = 1'b0;
  logic [INDEX_W-1:0]  cfg_index      = '0;
  logic [CFG_W-1:0]    cfg_data       = '0;

  // Requests waiting to be sent and outputs waiting to be seen.
  request_t   event_backlog[$];
  alarm_out_t awaited_outputs[$];
  request_t   next_req;
  int         queued_cnt   = 0;
  int         accepted_cnt = 0;
  int         fault_count  = 0;
  bit         req_taken    = 1'b0;
  int         idle_pct     = 0;
  int         stall_pct    = 0;

  // Mirror of the configuration registers.
  bit                  cfg_enable;
  logic [CFG_W-1:0]    cfg_ws, cfg_we, cfg_d1, cfg_d2;
  bit                  cfg_push, cfg_buzz;

  // Mirror of the controller state.
  logic [CODE_W-1:0]   alert_q;
  phase_t              phase_q;
  logic [WAIT_W-1:0]   waited_q;
  logic [BEEP_W-1:0]   beeps_q;
  bit                  ev_win, push_now, beep_now;

  alarm_escalation_controller uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .minute_of_day(minute_of_day),
    .clock_valid(clock_valid), .therapy_active(therapy_active),
    .out_valid(out_valid), .out_stall(out_stall),
    .alert_state(alert_state), .push_request(push_request),
    .beep_pulse(beep_pulse), .escalation_busy(escalation_busy),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Window test; an unset clock is never inside, and equal bounds mean all day.
  function automatic bit window_hit(input bit cv, input logic [MINUTE_W-1:0] m);
    if (!cv) return 1'b0;
    if (cfg_ws == cfg_we) return 1'b1;
    if (cfg_ws < cfg_we) return (m >= cfg_ws) && (m < cfg_we);
    return (m >= cfg_ws) || (m < cfg_we);
  endfunction

  function automatic void halt_escalation();
    phase_q  = PH_IDLE;
    waited_q = '0;
    beeps_q  = '0;
  endfunction

  function automatic void disarm_alarm();
    halt_escalation();
    alert_q = CODE_DISARMED;
  endfunction

  // Enter the buzzer stage: first beep at once, the rest on later ticks.
  function automatic void sound_buzzer();
    if (!ev_win) begin
      disarm_alarm();
      return;
    end
    if (cfg_buzz) begin
      alert_q  = CODE_BUZZING;
      beep_now = 1'b1;
      beeps_q  = BEEP_W'(BEEPS - 1);
      phase_q  = PH_BEEP;
      waited_q = '0;
    end else begin
      halt_escalation();
    end
  endfunction

  // The first delay has run out: push, then either wait again or buzz.
  function automatic void finish_first_wait();
    if (alert_q != CODE_PENDING) begin
      halt_escalation();
      return;
    end
    if (!ev_win) begin
      disarm_alarm();
      return;
    end
    if (cfg_push) begin
      alert_q  = CODE_PUSH_SENT;
      push_now = 1'b1;
    end
    if (cfg_push && cfg_buzz && cfg_d2 != 0) begin
      if (!cfg_enable || !ev_win) begin
        disarm_alarm();
        return;
      end
      phase_q  = PH_SECOND;
      waited_q = '0;
      return;
    end
    sound_buzzer();
  endfunction

  // Apply one request to the mirrored state and return the outputs it should give.
  function automatic alarm_out_t next_alarm_outputs(input request_t r);
    alarm_out_t o;
    int         limit;
    ev_win   = window_hit(r.cv, r.minute);
    push_now = 1'b0;
    beep_now = 1'b0;
    case (r.op)
      OP_REEVALUATE: begin
        if (!cfg_enable || !r.cv) begin
          if (alert_q != CODE_DISARMED && alert_q != CODE_ACKED) disarm_alarm();
        end else if (ev_win && r.therapy && alert_q == CODE_DISARMED) begin
          alert_q = CODE_ARMED;
        end else if (!ev_win && alert_q >= CODE_ARMED && alert_q <= CODE_BUZZING) begin
          disarm_alarm();
        end
      end
      OP_START: begin
        if (cfg_enable && r.cv && ev_win) begin
          halt_escalation();
          alert_q = CODE_ARMED;
        end
      end
      OP_STOP: begin
        if (cfg_enable && alert_q == CODE_ARMED) begin
          if (!ev_win) begin
            alert_q = CODE_DISARMED;
          end else begin
            halt_escalation();
            alert_q = CODE_PENDING;
            phase_q = PH_FIRST;
            if (cfg_d1 == 0) finish_first_wait();
          end
        end
      end
      OP_LINK_LOST: begin
        if (cfg_enable && alert_q != CODE_DISARMED) disarm_alarm();
      end
      OP_ACK: begin
        if (alert_q != CODE_DISARMED && alert_q != CODE_ACKED) begin
          halt_escalation();
          alert_q = CODE_ACKED;
        end
      end
      OP_TICK: begin
        case (phase_q)
          PH_FIRST, PH_SECOND: begin
            limit    = int'(phase_q == PH_FIRST ? cfg_d1 : cfg_d2) * SECS_PER_MINUTE;
            waited_q = waited_q + 1'b1;
            if (int'(waited_q) >= limit) begin
              if (phase_q == PH_FIRST) finish_first_wait();
              else sound_buzzer();
            end else if (!cfg_enable || !ev_win) begin
              disarm_alarm();
            end
          end
          PH_BEEP: begin
            if (beeps_q != 0) begin
              beep_now = 1'b1;
              beeps_q  = beeps_q - 1'b1;
            end else begin
              halt_escalation();
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    o.state = alert_q;
    o.push  = push_now;
    o.beep  = beep_now;
    o.busy  = (phase_q != PH_IDLE);
    return o;
  endfunction

  // Driver: present a new request once the previous one has gone.
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (!in_valid || req_taken) begin
        if (event_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_req = event_backlog.pop_front();
          in_valid       <= 1'b1;
          opcode         <= next_req.op;
          minute_of_day  <= next_req.minute;
          clock_valid    <= next_req.cv;
          therapy_active <= next_req.therapy;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    alarm_out_t want;
    request_t   seen;
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      req_taken = in_valid && !in_stall;
      if (req_taken) begin
        seen.op      = opcode;
        seen.minute  = minute_of_day;
        seen.cv      = clock_valid;
        seen.therapy = therapy_active;
        awaited_outputs.push_back(next_alarm_outputs(seen));
        accepted_cnt++;
      end
      if (out_valid && !out_stall) begin
        if (awaited_outputs.size() == 0) begin
          $error("result arrived with no request outstanding");
          fault_count++;
        end else begin
          want = awaited_outputs.pop_front();
          if (alert_state !== want.state) begin
            $error("alert_state: expected %0d, got %0d", want.state, alert_state);
            fault_count++;
          end
          if (push_request !== want.push) begin
            $error("push_request: expected %0b, got %0b", want.push, push_request);
            fault_count++;
          end
          if (beep_pulse !== want.beep) begin
            $error("beep_pulse: expected %0b, got %0b", want.beep, beep_pulse);
            fault_count++;
          end
          if (escalation_busy !== want.busy) begin
            $error("escalation_busy: expected %0b, got %0b", want.busy, escalation_busy);
            fault_count++;
          end
        end
      end
    end
  end

  task automatic add_request(input logic [OP_W-1:0] op, input logic [MINUTE_W-1:0] m,
                             input logic cv, input logic th);
    request_t r;
    r.op      = op;
    r.minute  = m;
    r.cv      = cv;
    r.therapy = th;
    event_backlog.push_back(r);
    queued_cnt++;
  endtask

  // Hold until every request has been taken and every result checked.
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || awaited_outputs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_ALERT_ENABLE:  cfg_enable = val[0];
      REG_WINDOW_START:  cfg_ws     = val;
      REG_WINDOW_END:    cfg_we     = val;
      REG_FIRST_DELAY:   cfg_d1     = val;
      REG_SECOND_DELAY:  cfg_d2     = val;
      REG_PUSH_ENABLE:   cfg_push   = val[0];
      REG_BUZZER_ENABLE: cfg_buzz   = val[0];
      default: ;
    endcase
  endtask

  // Rewrite the whole register set once the controller is idle.
  task automatic apply_setting(input int en, input int ws, input int we, input int d1,
                               input int d2, input int pe, input int be);
    wait_idle();
    write_reg(REG_ALERT_ENABLE, CFG_W'(en));
    write_reg(REG_WINDOW_START, CFG_W'(ws));
    write_reg(REG_WINDOW_END, CFG_W'(we));
    write_reg(REG_FIRST_DELAY, CFG_W'(d1));
    write_reg(REG_SECOND_DELAY, CFG_W'(d2));
    write_reg(REG_PUSH_ENABLE, CFG_W'(pe));
    write_reg(REG_BUZZER_ENABLE, CFG_W'(be));
  endtask

  // A minute inside or outside the current window, falling back to a bound.
  function automatic logic [MINUTE_W-1:0] pick_minute(input bit want_in);
    logic [MINUTE_W-1:0] m;
    for (int k = 0; k < 32; k++) begin
      m = MINUTE_W'($urandom_range(1439));
      if (window_hit(1'b1, m) == want_in) return m;
    end
    return want_in ? cfg_ws : cfg_we;
  endfunction

  // Mostly arm, stop and tick sequences, with the odd interruption and some noise.
  task automatic add_random_traffic(input int target);
    int made;
    int n;
    int cut;
    logic [MINUTE_W-1:0] m;
    made = 0;
    while (made < target) begin
      if ($urandom_range(3) != 0) begin
        m = pick_minute(1'b1);
        add_request($urandom_range(1) ? OP_REEVALUATE : OP_START, m, 1'b1, 1'b1);
        add_request(OP_STOP, m, 1'b1, 1'($urandom_range(1)));
        n = int'(cfg_d1) * SECS_PER_MINUTE + int'(cfg_d2) * SECS_PER_MINUTE + 8;
        if (n > 200) n = 200;
        n   = $urandom_range(n);
        cut = ($urandom_range(2) == 0) ? int'($urandom_range(n)) : -1;
        made += 2 + n;
        for (int i = 0; i < n; i++) begin
          if (i == cut) begin
            add_request(OP_W'($urandom_range(7)), pick_minute(1'($urandom_range(1))),
                        $urandom_range(3) != 0, 1'($urandom_range(1)));
            made++;
          end
          add_request(OP_TICK, m, 1'b1, 1'($urandom_range(1)));
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          add_request(OP_W'($urandom_range(7)), MINUTE_W'($urandom_range(2047)),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
          made++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int r_en, r_ws, r_we, r_d1, r_d2, r_pe, r_be;
    // Reset values of the registers and the controller.
    cfg_enable = 1'b0;
    cfg_ws     = 11'd1380;
    cfg_we     = 11'd360;
    cfg_d1     = 11'd5;
    cfg_d2     = 11'd5;
    cfg_push   = 1'b0;
    cfg_buzz   = 1'b1;
    alert_q    = CODE_DISARMED;
    phase_q    = PH_IDLE;
    waited_q   = '0;
    beeps_q    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Disabled controller with defaults, unused opcodes included.
    add_request(OP_REEVALUATE, 11'd1400, 1'b1, 1'b1);
    add_request(3'd6, 11'd0, 1'b1, 1'b1);

    // Wrapping window with no delays: push and buzzer in the stop step.
    apply_setting(1, 1380, 360, 0, 0, 1, 1);
    add_request(3'd7, 11'd2047, 1'b1, 1'b1);
    add_request(OP_REEVALUATE, 11'd1400, 1'b1, 1'b1);
    add_request(OP_STOP, 11'd1400, 1'b1, 1'b0);
    repeat (5) add_request(OP_TICK, 11'd1400, 1'b1, 1'b0);
    add_request(OP_ACK, 11'd1400, 1'b1, 1'b0);
    add_request(OP_START, 11'd359, 1'b1, 1'b1);
    add_request(OP_REEVALUATE, 11'd360, 1'b1, 1'b1);
    add_request(OP_START, 11'd0, 1'b0, 1'b1);
    add_request(OP_START, 11'd2047, 1'b1, 1'b0);
    add_request(OP_LINK_LOST, 11'd2047, 1'b1, 1'b0);

    // Both stages off: the alert stays pending with nothing running.
    apply_setting(1, 0, 0, 0, 0, 0, 0);
    add_request(OP_START, 11'd720, 1'b1, 1'b1);
    add_request(OP_STOP, 11'd720, 1'b1, 1'b0);
    add_request(OP_TICK, 11'd720, 1'b1, 1'b0);

    // Buzzer off: the sequence ends once the push has gone.
    apply_setting(1, 0, 0, 0, 0, 1, 0);
    add_request(OP_START, 11'd0, 1'b1, 1'b0);
    add_request(OP_STOP, 11'd0, 1'b1, 1'b0);

    // Push then a second wait, cut short by an acknowledgement.
    apply_setting(1, 0, 0, 0, 1, 1, 1);
    add_request(OP_START, 11'd1439, 1'b1, 1'b0);
    add_request(OP_STOP, 11'd1439, 1'b1, 1'b0);
    add_request(OP_ACK, 11'd1439, 1'b1, 1'b0);

    // Random phases, each under its own setting and idling pattern.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: apply_setting(1, 0, 0, 1, 1, 1, 1);
        1: apply_setting(1, 0, 1439, 0, 1, 1, 1);
        2: apply_setting(1, 1439, 0, 1, 0, 0, 1);
        3: apply_setting(0, 600, 1200, 1, 1, 1, 1);
        4: apply_setting(1, 2047, 100, 1, 1, 1, 1);
        5: apply_setting(1, 100, 1300, 1440, 1440, 1, 1);
        6: apply_setting(1, 700, 800, 0, 0, 0, 0);
        7: apply_setting(1, 1000, 200, 2, 1, 1, 0);
        default: begin
          // Upper bits of the one-bit registers carry junk that must be ignored.
          r_en = int'({10'($urandom_range(1023)), 1'($urandom_range(9) != 0)});
          r_ws = int'($urandom_range(1439));
          r_we = int'($urandom_range(1439));
          r_d1 = int'($urandom_range(2));
          r_d2 = int'($urandom_range(2));
          r_pe = int'({10'($urandom_range(1023)), 1'($urandom_range(1))});
          r_be = int'({10'($urandom_range(1023)), 1'($urandom_range(1))});
          apply_setting(r_en, r_ws, r_we, r_d1, r_d2, r_pe, r_be);
        end
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      add_random_traffic(110);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
